// ===== hw/rtl/weighted_deviation_anomaly_detector_defines.svh =====
// assertion helpers shared by the rtl files
`ifndef WEIGHTED_DEVIATION_ANOMALY_DETECTOR_DEFINES_SVH
`define WEIGHTED_DEVIATION_ANOMALY_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WDAD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wdad assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define WDAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wdad assertion failed");

`endif

// ===== hw/rtl/wdad_pkg.sv =====
package wdad_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int SCORE_W  = 40;
    localparam int VMEAN_W  = 24;
    localparam int SMEAN_W  = 16;
    localparam int WEIGHT_W = 8;
    localparam int LIMIT_W  = 16;
    localparam int FRAC_W   = 8;
    localparam int DIFF_W   = 24;
    localparam int PROD_W   = DIFF_W + WEIGHT_W;
    localparam int DEN_W    = 24;

    // configuration port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_VOLUME_MEAN      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME_DEVIATION = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_MEAN       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_DEVIATION  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME_WEIGHT    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_WEIGHT     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME_LIMIT     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT      = 3'd7;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // divider
    localparam int DIV_STEPS = SCORE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef struct packed {
        logic [VMEAN_W-1:0]  volume_mean;
        logic [DEN_W-1:0]    volume_deviation;
        logic [SMEAN_W-1:0]  speed_mean;
        logic [SMEAN_W-1:0]  speed_deviation;
        logic [WEIGHT_W-1:0] volume_weight;
        logic [WEIGHT_W-1:0] speed_weight;
        logic [LIMIT_W-1:0]  volume_limit;
        logic [LIMIT_W-1:0]  speed_limit;
    } cfg_t;

    typedef struct packed {
        logic               starts_day;
        logic               ends_day;
        logic [SCORE_W-1:0] num;
        logic [DEN_W-1:0]   den;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== hw/rtl/wdad_if.sv =====
// input item channel
interface wdad_in_if;
    logic                          valid;
    logic                          ready;
    logic                          starts_day;
    logic [wdad_pkg::SAMPLE_W-1:0] sample;
    logic                          ends_day;

    modport source (output valid, output starts_day, output sample, output ends_day,
                    input ready);
    modport sink (input valid, input starts_day, input sample, input ends_day,
                  output ready);
endinterface

// result item channel
interface wdad_out_if;
    logic                         valid;
    logic                         ready;
    logic [wdad_pkg::SCORE_W-1:0] volume_score;
    logic [wdad_pkg::SCORE_W-1:0] speed_score;
    logic                         volume_alarm;
    logic                         speed_alarm;

    modport source (output valid, output volume_score, output speed_score,
                    output volume_alarm, output speed_alarm, input ready);
    modport sink (input valid, input volume_score, input speed_score,
                  input volume_alarm, input speed_alarm, output ready);
endinterface

// ===== hw/rtl/wdad_cfg.sv =====
module wdad_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wdad_pkg::ADDR_W-1:0] paddr,
    input  logic [wdad_pkg::DATA_W-1:0] pwdata,
    output logic [wdad_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output wdad_pkg::cfg_t              cfg
);

    wdad_pkg::cfg_t                     cfg_reg;
    wdad_pkg::cfg_t                     cfg_next;
    logic [wdad_pkg::REG_IDX_W-1:0]     idx;
    logic                               wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[wdad_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                wdad_pkg::REG_VOLUME_MEAN:
                    cfg_next.volume_mean = pwdata[wdad_pkg::VMEAN_W-1:0];
                wdad_pkg::REG_VOLUME_DEVIATION:
                    cfg_next.volume_deviation = pwdata[wdad_pkg::DEN_W-1:0];
                wdad_pkg::REG_SPEED_MEAN:
                    cfg_next.speed_mean = pwdata[wdad_pkg::SMEAN_W-1:0];
                wdad_pkg::REG_SPEED_DEVIATION:
                    cfg_next.speed_deviation = pwdata[wdad_pkg::SMEAN_W-1:0];
                wdad_pkg::REG_VOLUME_WEIGHT:
                    cfg_next.volume_weight = pwdata[wdad_pkg::WEIGHT_W-1:0];
                wdad_pkg::REG_SPEED_WEIGHT:
                    cfg_next.speed_weight = pwdata[wdad_pkg::WEIGHT_W-1:0];
                wdad_pkg::REG_VOLUME_LIMIT:
                    cfg_next.volume_limit = pwdata[wdad_pkg::LIMIT_W-1:0];
                wdad_pkg::REG_SPEED_LIMIT:
                    cfg_next.speed_limit = pwdata[wdad_pkg::LIMIT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            wdad_pkg::REG_VOLUME_MEAN:
                prdata = wdad_pkg::DATA_W'(cfg_reg.volume_mean);
            wdad_pkg::REG_VOLUME_DEVIATION:
                prdata = wdad_pkg::DATA_W'(cfg_reg.volume_deviation);
            wdad_pkg::REG_SPEED_MEAN:
                prdata = wdad_pkg::DATA_W'(cfg_reg.speed_mean);
            wdad_pkg::REG_SPEED_DEVIATION:
                prdata = wdad_pkg::DATA_W'(cfg_reg.speed_deviation);
            wdad_pkg::REG_VOLUME_WEIGHT:
                prdata = wdad_pkg::DATA_W'(cfg_reg.volume_weight);
            wdad_pkg::REG_SPEED_WEIGHT:
                prdata = wdad_pkg::DATA_W'(cfg_reg.speed_weight);
            wdad_pkg::REG_VOLUME_LIMIT:
                prdata = wdad_pkg::DATA_W'(cfg_reg.volume_limit);
            wdad_pkg::REG_SPEED_LIMIT:
                prdata = wdad_pkg::DATA_W'(cfg_reg.speed_limit);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volume_mean      <= '0;
            cfg_reg.volume_deviation <= wdad_pkg::DEN_W'(256);
            cfg_reg.speed_mean       <= '0;
            cfg_reg.speed_deviation  <= wdad_pkg::SMEAN_W'(256);
            cfg_reg.volume_weight    <= wdad_pkg::WEIGHT_W'(1);
            cfg_reg.speed_weight     <= wdad_pkg::WEIGHT_W'(1);
            cfg_reg.volume_limit     <= wdad_pkg::LIMIT_W'(2);
            cfg_reg.speed_limit      <= wdad_pkg::LIMIT_W'(2);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/wdad_front.sv =====
module wdad_front (
    input  wdad_pkg::cfg_t            cfg,
    wdad_in_if.sink                   feed,
    input  wdad_pkg::queue_status_t   q_status,
    output logic                      push,
    output wdad_pkg::job_t            job
);

    logic [wdad_pkg::DIFF_W-1:0]   vol_value;
    logic [wdad_pkg::DIFF_W-1:0]   vol_diff;
    logic [wdad_pkg::SMEAN_W-1:0]  spd_diff;
    logic [wdad_pkg::DIFF_W-1:0]   diff;
    logic [wdad_pkg::WEIGHT_W-1:0] weight;
    logic [wdad_pkg::PROD_W-1:0]   product;

    assign feed.ready = !q_status.full;
    assign push       = feed.valid && feed.ready;

    // absolute deviation from the mean, volume count moved to q16.8
    assign vol_value = {feed.sample, {wdad_pkg::FRAC_W{1'b0}}};
    assign vol_diff  = (vol_value > cfg.volume_mean) ? (vol_value - cfg.volume_mean)
                                                     : (cfg.volume_mean - vol_value);
    assign spd_diff  = (feed.sample > cfg.speed_mean) ? (feed.sample - cfg.speed_mean)
                                                      : (cfg.speed_mean - feed.sample);

    // one shared weight multiplier for both kinds of item
    assign diff    = feed.starts_day ? vol_diff : wdad_pkg::DIFF_W'(spd_diff);
    assign weight  = feed.starts_day ? cfg.volume_weight : cfg.speed_weight;
    assign product = wdad_pkg::PROD_W'(diff) * wdad_pkg::PROD_W'(weight);

    // job for the back end: numerator scaled by 2^8, divisor picked by kind
    always_comb
    begin
        job.starts_day = feed.starts_day;
        job.ends_day   = feed.ends_day;
        job.num        = {product, {wdad_pkg::FRAC_W{1'b0}}};
        job.den        = feed.starts_day ? cfg.volume_deviation
                                         : wdad_pkg::DEN_W'(cfg.speed_deviation);
    end

endmodule

// ===== hw/rtl/wdad_queue.sv =====
`include "weighted_deviation_anomaly_detector_defines.svh"

module wdad_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  wdad_pkg::job_t           job_in,
    input  logic                     pop,
    output wdad_pkg::job_t           head,
    output wdad_pkg::queue_status_t  status
);

    wdad_pkg::job_t                 entry_reg [wdad_pkg::QUEUE_DEPTH];
    logic [wdad_pkg::PTR_W-1:0]     wr_ptr_reg;
    logic [wdad_pkg::PTR_W-1:0]     wr_ptr_next;
    logic [wdad_pkg::PTR_W-1:0]     rd_ptr_reg;
    logic [wdad_pkg::PTR_W-1:0]     rd_ptr_next;
    logic [wdad_pkg::CNT_W-1:0]     count_reg;
    logic [wdad_pkg::CNT_W-1:0]     count_next;

    localparam logic [wdad_pkg::PTR_W-1:0] LAST_PTR = wdad_pkg::PTR_W'(wdad_pkg::QUEUE_DEPTH - 1);
    localparam logic [wdad_pkg::CNT_W-1:0] FULL_CNT = wdad_pkg::CNT_W'(wdad_pkg::QUEUE_DEPTH);

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

    `WDAD_ASSERT_IMPL(queue_no_overflow, push, count_reg != FULL_CNT)
    `WDAD_ASSERT_IMPL(queue_no_underflow, pop, count_reg != '0)

endmodule

// ===== hw/rtl/wdad_back.sv =====
`include "weighted_deviation_anomaly_detector_defines.svh"

module wdad_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wdad_pkg::cfg_t           cfg,
    input  wdad_pkg::job_t           head,
    input  wdad_pkg::queue_status_t  q_status,
    output logic                     pop,
    wdad_out_if.source               report
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DIV   = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    localparam int SW = wdad_pkg::SCORE_W;
    localparam int DW = wdad_pkg::DEN_W;

    state_t                         state_reg;
    state_t                         state_next;
    logic [SW-1:0]                  dq_reg;
    logic [SW-1:0]                  dq_next;
    logic [DW-1:0]                  rem_reg;
    logic [DW-1:0]                  rem_next;
    logic [DW-1:0]                  den_reg;
    logic [DW-1:0]                  den_next;
    logic                           starts_reg;
    logic                           starts_next;
    logic                           ends_reg;
    logic                           ends_next;
    logic [wdad_pkg::STEP_W-1:0]    step_reg;
    logic [wdad_pkg::STEP_W-1:0]    step_next;
    logic [SW-1:0]                  volume_score_reg;
    logic [SW-1:0]                  volume_score_next;
    logic [SW-1:0]                  speed_sum_reg;
    logic [SW-1:0]                  speed_sum_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [SW-1:0]                  out_volume_reg;
    logic [SW-1:0]                  out_volume_next;
    logic [SW-1:0]                  out_speed_reg;
    logic [SW-1:0]                  out_speed_next;
    logic                           out_valarm_reg;
    logic                           out_valarm_next;
    logic                           out_salarm_reg;
    logic                           out_salarm_next;

    logic [DW:0]                    trial;
    logic                           fits;
    logic [SW:0]                    sum_wide;
    logic [SW-1:0]                  sum_sat;
    logic [SW-1:0]                  new_volume;
    logic [SW-1:0]                  new_speed;
    logic [SW-1:0]                  vol_thresh;
    logic [SW-1:0]                  spd_thresh;
    logic                           out_free;

    localparam logic [wdad_pkg::STEP_W-1:0] LAST_STEP =
        wdad_pkg::STEP_W'(wdad_pkg::DIV_STEPS - 1);

    // one restoring division step
    assign trial = {rem_reg, dq_reg[SW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    // saturating day accumulation
    assign sum_wide   = {1'b0, speed_sum_reg} + {1'b0, dq_reg};
    assign sum_sat    = sum_wide[SW] ? wdad_pkg::SCORE_MAX : sum_wide[SW-1:0];
    assign new_volume = starts_reg ? dq_reg : volume_score_reg;
    assign new_speed  = starts_reg ? '0 : sum_sat;
    assign vol_thresh = SW'({cfg.volume_limit, {wdad_pkg::FRAC_W{1'b0}}});
    assign spd_thresh = SW'({cfg.speed_limit, {wdad_pkg::FRAC_W{1'b0}}});

    assign out_free = !out_valid_reg || report.ready;
    assign pop      = (state_reg == S_IDLE) && !q_status.empty;

    assign report.valid        = out_valid_reg;
    assign report.volume_score = out_volume_reg;
    assign report.speed_score  = out_speed_reg;
    assign report.volume_alarm = out_valarm_reg;
    assign report.speed_alarm  = out_salarm_reg;

    // sequencer: take job, divide (skipped for a zero divisor), apply to day state, report at day end
    always_comb
    begin
        state_next        = state_reg;
        dq_next           = dq_reg;
        rem_next          = rem_reg;
        den_next          = den_reg;
        starts_next       = starts_reg;
        ends_next         = ends_reg;
        step_next         = step_reg;
        volume_score_next = volume_score_reg;
        speed_sum_next    = speed_sum_reg;
        out_valid_next    = out_valid_reg && !report.ready;
        out_volume_next   = out_volume_reg;
        out_speed_next    = out_speed_reg;
        out_valarm_next   = out_valarm_reg;
        out_salarm_next   = out_salarm_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    den_next    = head.den;
                    starts_next = head.starts_day;
                    ends_next   = head.ends_day;
                    rem_next    = '0;
                    step_next   = LAST_STEP;
                    // zero divisor reads as a saturated quotient
                    if (head.den == '0)
                    begin
                        dq_next    = wdad_pkg::SCORE_MAX;
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        dq_next    = head.num;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next  = fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
                dq_next   = {dq_reg[SW-2:0], fits};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (!ends_reg)
                begin
                    volume_score_next = new_volume;
                    speed_sum_next    = new_speed;
                    state_next        = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_volume_next   = new_volume;
                    out_speed_next    = new_speed;
                    out_valarm_next   = (new_volume > vol_thresh);
                    out_salarm_next   = (new_speed > spd_thresh);
                    volume_score_next = '0;
                    speed_sum_next    = '0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            volume_score_reg <= '0;
            speed_sum_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            volume_score_reg <= volume_score_next;
            speed_sum_reg    <= speed_sum_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        starts_reg     <= starts_next;
        ends_reg       <= ends_next;
        step_reg       <= step_next;
        out_volume_reg <= out_volume_next;
        out_speed_reg  <= out_speed_next;
        out_valarm_reg <= out_valarm_next;
        out_salarm_reg <= out_salarm_next;
    end

    `WDAD_ASSERT_NEXT(div_leads_to_apply, (state_reg == S_DIV) && (step_reg == '0),
                      state_reg == S_APPLY)
    `WDAD_ASSERT_NEXT(zero_den_saturates, pop && (head.den == '0),
                      (state_reg == S_APPLY) && (dq_reg == wdad_pkg::SCORE_MAX))
    `WDAD_ASSERT_NEXT(day_end_reports, (state_reg == S_APPLY) && ends_reg && out_free,
                      out_valid_reg && (volume_score_reg == '0) && (speed_sum_reg == '0))

endmodule

// ===== hw/rtl/weighted_deviation_anomaly_detector.sv =====
// an item is queued, divided in S_DIV, applied in S_APPLY; a zero divisor skips S_DIV
// the back end pops a job only in idle; one job at a time runs the 40-step serial divider
// a two-entry job queue lets the input side accept items while the divider is busy
// reset: rst_n asynchronous active low; registers take their documented defaults,
// day state clears to zero, queue and result register empty
module weighted_deviation_anomaly_detector (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wdad_pkg::ADDR_W-1:0] paddr,
    input  logic [wdad_pkg::DATA_W-1:0] pwdata,
    output logic [wdad_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    wdad_in_if.sink                     feed,
    wdad_out_if.source                  report
);

    wdad_pkg::cfg_t           cfg;
    wdad_pkg::job_t           job;
    wdad_pkg::job_t           head;
    wdad_pkg::queue_status_t  q_status;
    logic                     push;
    logic                     pop;

    // register file
    wdad_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // item classification and numerator
    wdad_front u_front (
        .cfg      (cfg),
        .feed     (feed),
        .q_status (q_status),
        .push     (push),
        .job      (job)
    );

    // job queue
    wdad_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .job_in (job),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    // divider and day state
    wdad_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .report   (report)
    );

endmodule
